### rtl/fokt_pkg.sv
// shared types and constants for the frequency ordered key table
// depends on nothing; imported by fokt_ctrl, fokt_dp and the top level
`default_nettype none

package fokt_pkg;

    // table geometry
    localparam int DEPTH      = 32;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TOT_W      = $clog2(DEPTH + 1);

    // field widths of the items
    localparam int KEY_W   = 8;
    localparam int OCOUNT_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ACCESS = 2'd1,
        OP_EMIT   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // input item
    typedef struct packed {
        t_op              opcode;
        logic [KEY_W-1:0] key;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status             status;
        logic [KEY_W-1:0]    out_key;
        logic [OCOUNT_W-1:0] out_count;
        logic                last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // append the live key with zero count
        logic clr;        // empty the table
        logic latch;      // capture the live key for a lookup
        logic scan_rst;   // index back to zero
        logic scan_inc;   // index up by one
        logic incr;       // saturating count increment at the index
        logic sort_step;  // one odd-even compare and exchange phase
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic                  total_zero;
        logic                  full;
        logic                  match;
        logic                  idx_end;
        logic                  idx_last;
        logic [KEY_W-1:0]      rd_key;
        logic [COUNT_BITS-1:0] rd_count;
    } t_stat;

endpackage

`default_nettype wire

### rtl/frequency_ordered_key_table_unit.sv
// top level of the frequency ordered key table
// depends on fokt_pkg, fokt_ctrl and fokt_dp
`default_nettype none

// Byte-key table of DEPTH entries with saturating access counts. An item is
// taken when start is high and busy is low. Load and clear leave the unit
// idle; a load result appears on the cycle after. Access scans the table one
// entry per cycle until the key matches or the entries run out. Emit runs
// total odd-even sort phases, one per cycle, then streams total results, one
// per cycle. Each result is shown for one cycle with o_valid and cannot be
// held off; last marks the final result of an item. Clear gives no result.
module frequency_ordered_key_table_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    input  wire fokt_pkg::t_in_item  i_item,
    output logic                     busy,
    output logic                     o_valid,
    output fokt_pkg::t_out_item      o_item
);
    import fokt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fokt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .busy     (busy),
        .o_cmd    (cmd),
        .o_valid  (o_valid),
        .o_item   (o_item)
    );

    fokt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_item.key),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

`default_nettype wire

### rtl/fokt_dp.sv
// datapath: key and count rows, entry total, scan index and sort network
// depends on fokt_pkg; driven by fokt_ctrl commands
`default_nettype none

module fokt_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [fokt_pkg::KEY_W-1:0] i_key,
    input  wire fokt_pkg::t_cmd           i_cmd,
    output fokt_pkg::t_stat               o_stat
);
    import fokt_pkg::*;

    logic [KEY_W-1:0]      r_key [DEPTH];
    logic [COUNT_BITS-1:0] r_cnt [DEPTH];
    logic [KEY_W-1:0]      n_key [DEPTH];
    logic [COUNT_BITS-1:0] n_cnt [DEPTH];
    logic [TOT_W-1:0]      r_total;
    logic [TOT_W-1:0]      r_idx;
    logic [KEY_W-1:0]      r_find;
    logic [IDX_W-1:0]      rd_idx;

    assign rd_idx = r_idx[IDX_W-1:0];

    // table update: append, saturating increment, one sort phase
    always_comb begin
        n_key = r_key;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_key[r_total[IDX_W-1:0]] = i_key;
            n_cnt[r_total[IDX_W-1:0]] = '0;
        end
        if (i_cmd.incr && (r_cnt[rd_idx] != '1)) begin
            n_cnt[rd_idx] = r_cnt[rd_idx] + 1'b1;
        end
        if (i_cmd.sort_step) begin
            // pairs of this phase are disjoint; swap only on strictly less keeps it stable
            for (int j = 0; j < DEPTH - 1; j++) begin
                if ((1'(j) == r_idx[0]) && (TOT_W'(j + 1) < r_total)
                        && (r_cnt[j] < r_cnt[j+1])) begin
                    n_key[j]   = r_key[j+1];
                    n_cnt[j]   = r_cnt[j+1];
                    n_key[j+1] = r_key[j];
                    n_cnt[j+1] = r_cnt[j];
                end
            end
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_cnt <= n_cnt;
        if (i_cmd.latch) begin
            r_find <= i_key;
        end
    end

    // entry total and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_total <= '0;
            end else if (i_cmd.load) begin
                r_total <= r_total + 1'b1;
            end
            if (i_cmd.scan_rst) begin
                r_idx <= '0;
            end else if (i_cmd.scan_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.total_zero = (r_total == '0);
        o_stat.full       = (r_total == TOT_W'(DEPTH));
        o_stat.rd_key     = r_key[rd_idx];
        o_stat.rd_count   = r_cnt[rd_idx];
        o_stat.match      = (r_key[rd_idx] == r_find);
        o_stat.idx_end    = (r_idx >= r_total);
        o_stat.idx_last   = ((r_idx + 1'b1) == r_total);
    end

endmodule

`default_nettype wire

### rtl/fokt_ctrl.sv
// controller: command decode, lookup scan, sort phases and emit sequencing
// depends on fokt_pkg; steers fokt_dp and owns the result register
`default_nettype none

module fokt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire fokt_pkg::t_op      i_opcode,
    input  wire fokt_pkg::t_stat    i_stat,
    output logic                    busy,
    output fokt_pkg::t_cmd          o_cmd,
    output logic                    o_valid,
    output fokt_pkg::t_out_item     o_item
);
    import fokt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SORT,
        S_EMIT
    } t_state;

    t_state    r_state, n_state;
    logic      r_valid, n_valid;
    t_out_item r_res, n_res;
    logic      accept;

    assign accept  = start && (r_state == S_IDLE);
    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_item  = r_res;

    // next state, commands and result
    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_res   = '{status: ST_OK, out_key: '0, out_count: '0, last: 1'b1};
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        OP_LOAD: begin
                            n_valid = 1'b1;
                            if (i_stat.full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                o_cmd.load = 1'b1;
                            end
                        end
                        OP_ACCESS: begin
                            o_cmd.latch    = 1'b1;
                            o_cmd.scan_rst = 1'b1;
                            n_state        = S_SCAN;
                        end
                        OP_EMIT: begin
                            if (i_stat.total_zero) begin
                                n_valid      = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                o_cmd.scan_rst = 1'b1;
                                n_state        = S_SORT;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            // walk the table for the first matching key
            S_SCAN: begin
                if (i_stat.idx_end) begin
                    n_valid      = 1'b1;
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else if (i_stat.match) begin
                    o_cmd.incr = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            // one phase per entry, index parity picks the pairs
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.scan_rst = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            // stream entries in table order
            S_EMIT: begin
                n_valid         = 1'b1;
                n_res.out_key   = i_stat.rd_key;
                n_res.out_count = OCOUNT_W'(i_stat.rd_count);
                n_res.last      = i_stat.idx_last;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end

`ifndef SYNTHESIS
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_res.last) |-> (r_state == S_EMIT))
        else $error("non-final result outside emit");
    a_access_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_ACCESS)) |=> (r_state == S_SCAN))
        else $error("access did not start a scan");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.status == ST_EMPTY)) |-> r_res.last)
        else $error("empty status not final");
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !i_stat.idx_end)
        else $error("emit index past entry total");
`endif

endmodule

`default_nettype wire
